>>> sv/mtcqf_pkg.sv
package mtcqf_pkg;

  // Event kinds on the input tuser.
  localparam logic [1:0] OP_QF     = 2'd0;
  localparam logic [1:0] OP_LOCATE = 2'd1;
  localparam logic [1:0] OP_IDLE   = 2'd2;

  // Rate codes.
  localparam logic [1:0] RATE_24   = 2'd0;
  localparam logic [1:0] RATE_25   = 2'd1;
  localparam logic [1:0] RATE_DROP = 2'd2;
  localparam logic [1:0] RATE_30   = 2'd3;

  // Register index, taken from paddr[2].
  localparam logic REG_IDLE_LIMIT = 1'b0;

  localparam int POS_W    = 56;
  localparam int DIGIT_W  = 4;
  localparam int DIGITS   = POS_W / DIGIT_W;
  localparam int CNT_W    = 4;
  localparam int REM_W    = 15;
  localparam int FRAMES_W = 22;

  localparam logic [19:0] IDLE_LIMIT_RESET = 20'd100000;
  localparam logic [23:0] IDLE_MAX         = 24'hFFFFFF;

  // floor(x / 10) for x below 4096 as (x * 6554) >> 16.
  localparam logic [24:0] DIV10_MUL   = 25'd6554;
  localparam int          DIV10_SHIFT = 16;

  localparam logic [31:0] DROP_MUL = 32'd1001;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PREP1 = 6'b000010,
    ST_PREP2 = 6'b000100,
    ST_PREP3 = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_FIN   = 6'b100000
  } state_t;

  // One frame period, round(2^32 / fps).
  function automatic logic [27:0] frame_q32(input logic [1:0] rate);
    case (rate)
      RATE_24:   return 28'd178956971;
      RATE_25:   return 28'd171798692;
      RATE_DROP: return 28'd143308742;
      default:   return 28'd143165577;
    endcase
  endfunction

  // One quarter-frame period, round(2^32 / (4 * fps)).
  function automatic logic [25:0] quarter_q32(input logic [1:0] rate);
    case (rate)
      RATE_24:   return 26'd44739243;
      RATE_25:   return 26'd42949673;
      RATE_DROP: return 26'd35827186;
      default:   return 26'd35791394;
    endcase
  endfunction

  // Frames per second used to count frames; drop frame counts at 30.
  function automatic logic [4:0] fps_count(input logic [1:0] rate);
    case (rate)
      RATE_24: return 5'd24;
      RATE_25: return 5'd25;
      default: return 5'd30;
    endcase
  endfunction

  // Divisor of the time division; drop frame divides frames * 1001 by 30000.
  function automatic logic [14:0] time_divisor(input logic [1:0] rate);
    case (rate)
      RATE_24:   return 15'd24;
      RATE_25:   return 15'd25;
      RATE_DROP: return 15'd30000;
      default:   return 15'd30;
    endcase
  endfunction

  // Half the divisor, added before the division to round half up.
  function automatic logic [14:0] time_half(input logic [1:0] rate);
    case (rate)
      RATE_24:   return 15'd12;
      RATE_25:   return 15'd12;
      RATE_DROP: return 15'd15000;
      default:   return 15'd15;
    endcase
  endfunction

endpackage

>>> sv/midi_timecode_quarter_frame_reader.sv
// Channel   Direction  Handshake                 Contents
// s_*       in         s_tvalid / s_tready       one event, kind in s_tuser
// m_*       out        m_tvalid / m_tready       position, play, rate, timecode
// APB       in/out     psel, penable, pready=1   idle_limit_us at byte address 0
//
// Quarter frames that complete no timecode, idle ticks and unused kinds go from the
// idle state to the final state; locates and completing quarter frames pass the setup
// states PREP1 to PREP3, 14 radix-16 steps of serial long division and the final state.
// A new event is taken once the previous result sits in the output register.
// Reset is synchronous; the output register holds through m_tready stalls.
module midi_timecode_quarter_frame_reader
  import mtcqf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [7:0] qf_byte, [12:8] locate_hours, [18:13] locate_minutes,
  // [24:19] locate_seconds, [29:25] locate_frames, [31:30] locate_rate,
  // [51:32] idle_us, [55:52] zero
  input  logic [55:0] s_tdata,
  // [1:0] opcode
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [55:0] position_q32, [56] playing, [58:57] current_rate, [59] assembled,
  // [64:60] tc_hours, [72:65] tc_minutes, [80:73] tc_seconds,
  // [88:81] tc_frames, [95:89] zero
  output logic [95:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  state_t state;

  logic [3:0]       nib [8];
  logic [3:0]       nib_m [8];
  logic [7:0]       present;
  logic [7:0]       present_m;
  logic [POS_W-1:0] position;
  logic             play;
  logic [23:0]      idle_acc;
  logic [1:0]       rate_code;
  logic [19:0]      idle_limit;

  logic [4:0]       w_h;
  logic [7:0]       w_m;
  logic [7:0]       w_s;
  logic [7:0]       w_f;
  logic [1:0]       w_rate;
  logic             w_div;
  logic             w_assembled;

  logic [16:0]         base;
  logic [11:0]         tmin;
  logic [FRAMES_W-1:0] frames;
  logic [12:0]         dropped;
  logic [REM_W-1:0]    rem;
  logic [REM_W-1:0]    rem_next;
  logic [POS_W-1:0]    quo;
  logic [DIGIT_W-1:0]  qdig;
  logic [CNT_W-1:0]    cnt;
  logic [REM_W-1:0]    dvs;

  logic [7:0]  in_qf;
  logic [4:0]  loc_h;
  logic [5:0]  loc_m;
  logic [5:0]  loc_s;
  logic [4:0]  loc_f;
  logic [1:0]  loc_rate;
  logic [19:0] in_idle;
  logic [2:0]  piece;
  logic        qf_assemble;
  logic        need_div;
  logic [24:0] idle_sum;
  logic [23:0] idle_sat;
  logic [11:0] tdiv10;
  logic [24:0] tmin_prod;
  logic [FRAMES_W-1:0] fr;
  logic [31:0] divd_hi;
  logic [POS_W-1:0] pos_out;
  logic [88:0] out_data;
  logic        cfg_write;

  assign in_qf    = s_tdata[7:0];
  assign loc_h    = s_tdata[12:8];
  assign loc_m    = s_tdata[18:13];
  assign loc_s    = s_tdata[24:19];
  assign loc_f    = s_tdata[29:25];
  assign loc_rate = s_tdata[31:30];
  assign in_idle  = s_tdata[51:32];
  assign piece    = in_qf[6:4];

  assign s_tready = (state == ST_IDLE);
  assign m_tdata  = {7'd0, out_data};
  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == REG_IDLE_LIMIT) ? {12'd0, idle_limit} : 32'd0;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_IDLE_LIMIT);

  // Nibble store as it stands once this quarter frame is written.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      nib_m[i] = (piece == 3'(i)) ? in_qf[3:0] : nib[i];
    end
    present_m = present | (8'd1 << piece);
  end

  assign qf_assemble = (s_tuser == OP_QF) && (piece == 3'd7) && (&present_m);
  assign need_div    = (s_tuser == OP_LOCATE) || qf_assemble;
  assign idle_sum    = {1'b0, idle_acc} + 25'(in_idle);
  assign idle_sat    = idle_sum[24] ? IDLE_MAX : idle_sum[23:0];

  assign tmin_prod = 25'(tmin) * DIV10_MUL;
  assign tdiv10    = 12'(tmin_prod >> DIV10_SHIFT);
  assign fr        = frames - FRAMES_W'(dropped);
  assign divd_hi   = (w_rate == RATE_DROP) ? 32'(fr) * DROP_MUL : 32'(fr);
  assign dvs       = time_divisor(w_rate);

  // One radix-16 digit of restoring division; the partial remainder stays below dvs.
  always_comb begin
    logic [REM_W-1:0] r;
    logic [REM_W:0]   t;
    r = rem;
    for (int k = 0; k < DIGIT_W; k++) begin
      t = {r, quo[POS_W-1-k]};
      if (t >= {1'b0, dvs}) begin
        r = REM_W'(t - {1'b0, dvs});
        qdig[DIGIT_W-1-k] = 1'b1;
      end else begin
        r = t[REM_W-1:0];
        qdig[DIGIT_W-1-k] = 1'b0;
      end
    end
    rem_next = r;
  end

  always_comb begin
    if (!w_div) begin
      pos_out = position;
    end else if (w_assembled) begin
      pos_out = quo + POS_W'({frame_q32(rate_code), 1'b0});
    end else begin
      pos_out = quo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      for (int i = 0; i < 8; i++) begin
        nib[i] <= 4'd0;
      end
      present    <= 8'd0;
      position   <= '0;
      play       <= 1'b0;
      idle_acc   <= 24'd0;
      rate_code  <= RATE_30;
      idle_limit <= IDLE_LIMIT_RESET;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_write) begin
        idle_limit <= pwdata[19:0];
      end
      // In the final state the output register is reloaded below instead.
      if (m_tvalid && m_tready && (state != ST_FIN)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            w_div       <= need_div;
            w_assembled <= qf_assemble;
            case (s_tuser)
              OP_QF: begin
                nib      <= nib_m;
                present  <= (piece == 3'd7) ? 8'd0 : present_m;
                play     <= 1'b1;
                idle_acc <= 24'd0;
                position <= position + POS_W'(quarter_q32(rate_code));
                if (qf_assemble) begin
                  rate_code <= nib_m[7][2:1];
                end
                w_h    <= {nib_m[7][0], nib_m[6]};
                w_m    <= {nib_m[5], nib_m[4]};
                w_s    <= {nib_m[3], nib_m[2]};
                w_f    <= {nib_m[1], nib_m[0]};
                w_rate <= nib_m[7][2:1];
              end
              OP_LOCATE: begin
                rate_code <= loc_rate;
                w_h       <= loc_h;
                w_m       <= 8'(loc_m);
                w_s       <= 8'(loc_s);
                w_f       <= 8'(loc_f);
                w_rate    <= loc_rate;
              end
              OP_IDLE: begin
                idle_acc <= idle_sat;
                if (idle_sat > {4'd0, idle_limit}) begin
                  play <= 1'b0;
                end
              end
              default: begin
              end
            endcase
            state <= need_div ? ST_PREP1 : ST_FIN;
          end
        end
        ST_PREP1: begin
          base  <= 17'(w_h) * 17'd3600 + 17'(w_m) * 17'd60 + 17'(w_s);
          tmin  <= 12'(w_h) * 12'd60 + 12'(w_m);
          state <= ST_PREP2;
        end
        ST_PREP2: begin
          frames  <= FRAMES_W'(base) * FRAMES_W'(fps_count(w_rate)) + FRAMES_W'(w_f);
          dropped <= (w_rate == RATE_DROP) ? {tmin - tdiv10, 1'b0} : 13'd0;
          state   <= ST_PREP3;
        end
        ST_PREP3: begin
          // Dividend is frames (times 1001 for drop frame) * 2^32 plus half the divisor;
          // its top byte is always below the divisor, so it seeds the remainder directly.
          rem   <= REM_W'(divd_hi[31:24]);
          quo   <= {divd_hi[23:0], 17'd0, time_half(w_rate)};
          cnt   <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          rem <= rem_next;
          quo <= {quo[POS_W-DIGIT_W-1:0], qdig};
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(DIGITS - 1)) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!m_tvalid || m_tready) begin
            position <= pos_out;
            out_data <= {nib[1], nib[0], nib[3], nib[2], nib[5], nib[4],
                         nib[7][0], nib[6], w_assembled, rate_code, play, pos_out};
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken again before the event finished");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem < dvs))
    else $error("division remainder not below divisor");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_FIN))
    else $error("result appeared outside the final state");

  a_assembled_clears: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && w_div && w_assembled) |-> (present == 8'd0))
    else $error("have-flags not cleared after assembly");

endmodule
